/* src/iqmn_pkg.sv */
package iqmn_pkg;

	localparam int INDEX_W = 8;
	localparam int INDEX_SPAN = 1 << INDEX_W;
	localparam int CAP_W = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	localparam logic ACT_PUT = 1'b0;
	localparam logic ACT_GET = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		U_FETCH     = 4'd0,
		U_DECODE    = 4'd1,
		U_LINK_A    = 4'd2,
		U_LINK_B    = 4'd3,
		U_MOVE      = 4'd4,
		U_GET       = 4'd5,
		U_FIN_OK    = 4'd6,
		U_FIN_RANGE = 4'd7,
		U_FIN_EMPTY = 4'd8
	} upc_t;

	typedef enum logic [1:0] {NW_NONE, NW_X_SENT, NW_TAIL_X, NW_B_A} nw_op_t;
	typedef enum logic [1:0] {OL_NONE, OL_X_TAIL, OL_A_B, OL_A_SENT} ol_op_t;
	typedef enum logic [1:0] {HD_NONE, HD_X_IF_EMPTY, HD_A_IF_B_SENT, HD_A} hd_op_t;
	typedef enum logic [1:0] {TL_NONE, TL_X, TL_SENT_IF_A_SENT} tl_op_t;
	typedef enum logic [1:0] {PR_NONE, PR_SET_X, PR_CLR_HEAD} pr_op_t;
	typedef enum logic [2:0] {BR_ACCEPT, BR_DISPATCH, BR_NEXT, BR_GOTO, BR_FINISH} br_t;

	typedef struct packed {
		logic       rd_en;
		nw_op_t     nw;
		ol_op_t     ol;
		hd_op_t     hd;
		tl_op_t     tl;
		pr_op_t     pr;
		logic       val_ld;
		logic [1:0] status;
		br_t        br;
		upc_t       target;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		logic   take;
		logic   out_ld;
	} ctl_t;

	typedef struct packed {
		logic act_get;
		logic range_err;
		logic present;
		logic is_tail;
		logic empty;
		logic out_free;
	} flags_t;

	function automatic uword_t urom(input upc_t pc);
		uword_t w;
		w = '0;
		case (pc)
			U_FETCH: begin
				w.br = BR_ACCEPT;
			end
			U_DECODE: begin
				w.rd_en = 1'b1;
				w.br = BR_DISPATCH;
			end
			U_LINK_A: begin
				w.nw = NW_X_SENT;
				w.ol = OL_X_TAIL;
				w.br = BR_NEXT;
			end
			U_LINK_B: begin
				w.nw = NW_TAIL_X;
				w.hd = HD_X_IF_EMPTY;
				w.tl = TL_X;
				w.pr = PR_SET_X;
				w.br = BR_GOTO;
				w.target = U_FIN_OK;
			end
			U_MOVE: begin
				w.ol = OL_A_B;
				w.nw = NW_B_A;
				w.hd = HD_A_IF_B_SENT;
				w.br = BR_GOTO;
				w.target = U_LINK_A;
			end
			U_GET: begin
				w.ol = OL_A_SENT;
				w.tl = TL_SENT_IF_A_SENT;
				w.hd = HD_A;
				w.pr = PR_CLR_HEAD;
				w.val_ld = 1'b1;
				w.br = BR_GOTO;
				w.target = U_FIN_OK;
			end
			U_FIN_OK: begin
				w.status = ST_OK;
				w.br = BR_FINISH;
			end
			U_FIN_RANGE: begin
				w.status = ST_RANGE;
				w.br = BR_FINISH;
			end
			U_FIN_EMPTY: begin
				w.status = ST_EMPTY;
				w.br = BR_FINISH;
			end
			default: begin
				w.br = BR_GOTO;
				w.target = U_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

/* src/iqmn_ram.sv */
module iqmn_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/iqmn_seq.sv */
module iqmn_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  iqmn_pkg::flags_t flags,
	output iqmn_pkg::ctl_t   ctl
);

	import iqmn_pkg::*;

	upc_t   upc_q;
	upc_t   upc_nxt;
	uword_t uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_FETCH;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	always_comb begin
		uw = urom(upc_q);
		in_stall = (upc_q != U_FETCH);
		ctl.uw = uw;
		ctl.take = (upc_q == U_FETCH) && in_valid;
		ctl.out_ld = (uw.br == BR_FINISH) && flags.out_free;
		upc_nxt = upc_q;
		case (uw.br)
			BR_ACCEPT: begin
				upc_nxt = in_valid ? U_DECODE : U_FETCH;
			end
			BR_DISPATCH: begin
				if (flags.act_get) begin
					upc_nxt = flags.empty ? U_FIN_EMPTY : U_GET;
				end else if (flags.range_err) begin
					upc_nxt = U_FIN_RANGE;
				end else if (!flags.present) begin
					upc_nxt = U_LINK_A;
				end else if (flags.is_tail) begin
					upc_nxt = U_FIN_OK;
				end else begin
					upc_nxt = U_MOVE;
				end
			end
			BR_NEXT: begin
				upc_nxt = upc_t'(upc_q + 4'd1);
			end
			BR_GOTO: begin
				upc_nxt = uw.target;
			end
			BR_FINISH: begin
				upc_nxt = flags.out_free ? U_FETCH : upc_q;
			end
			default: begin
				upc_nxt = U_FETCH;
			end
		endcase
	end

endmodule

/* src/iqmn_dp.sv */
module iqmn_dp #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  iqmn_pkg::ctl_t                  ctl,
	output iqmn_pkg::flags_t                flags,
	input  logic                            cfg_we,
	input  logic [iqmn_pkg::CAP_W-1:0]      cfg_wdata,
	input  logic                            action,
	input  logic [iqmn_pkg::INDEX_W-1:0]    index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [iqmn_pkg::INDEX_W-1:0]    value
);

	import iqmn_pkg::*;

	localparam int NUM_SLOTS = (MAX_ENTRIES < INDEX_SPAN) ? MAX_ENTRIES : INDEX_SPAN;
	localparam int AW = $clog2(NUM_SLOTS);
	localparam int SW = $clog2(NUM_SLOTS + 1);
	localparam logic [SW-1:0] SENT_LINK = SW'(NUM_SLOTS);
	localparam logic [CAP_W-1:0] SLOTS_CAP = CAP_W'(NUM_SLOTS);

	logic [CAP_W-1:0]   capacity_q;
	logic [INDEX_W-1:0] idx_q;
	logic               act_q;
	logic [INDEX_W-1:0] value_q;
	logic [SW-1:0]      head_q;
	logic [SW-1:0]      tail_q;
	logic [NUM_SLOTS-1:0] present_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [INDEX_W-1:0] out_value_q;

	logic [AW-1:0] x_addr;
	logic [SW-1:0] x_link;
	logic [AW-1:0] head_addr;
	logic [AW-1:0] rd_addr;
	logic [SW-1:0] a_link;
	logic [SW-1:0] b_link;
	logic          a_sent;
	logic          b_sent;
	logic          tail_sent;

	logic          nw_we;
	logic [AW-1:0] nw_addr;
	logic [SW-1:0] nw_data;
	logic          ol_we;
	logic [AW-1:0] ol_addr;
	logic [SW-1:0] ol_data;

	assign x_addr = idx_q[AW-1:0];
	assign x_link = SW'(x_addr);
	assign head_addr = head_q[AW-1:0];
	assign rd_addr = act_q ? head_addr : x_addr;
	assign a_sent = (a_link == SENT_LINK);
	assign b_sent = (b_link == SENT_LINK);
	assign tail_sent = (tail_q == SENT_LINK);

	always_comb begin
		nw_we = 1'b0;
		nw_addr = x_addr;
		nw_data = SENT_LINK;
		case (ctl.uw.nw)
			NW_X_SENT: begin
				nw_we = 1'b1;
			end
			NW_TAIL_X: begin
				nw_we = !tail_sent;
				nw_addr = tail_q[AW-1:0];
				nw_data = x_link;
			end
			NW_B_A: begin
				nw_we = !b_sent;
				nw_addr = b_link[AW-1:0];
				nw_data = a_link;
			end
			default: begin
				nw_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		ol_we = 1'b0;
		ol_addr = x_addr;
		ol_data = tail_q;
		case (ctl.uw.ol)
			OL_X_TAIL: begin
				ol_we = 1'b1;
			end
			OL_A_B: begin
				ol_we = 1'b1;
				ol_addr = a_link[AW-1:0];
				ol_data = b_link;
			end
			OL_A_SENT: begin
				ol_we = !a_sent;
				ol_addr = a_link[AW-1:0];
				ol_data = SENT_LINK;
			end
			default: begin
				ol_we = 1'b0;
			end
		endcase
	end

	iqmn_ram #(
		.WIDTH(SW),
		.DEPTH(NUM_SLOTS)
	) u_newer (
		.clk  (clk),
		.we   (nw_we),
		.waddr(nw_addr),
		.wdata(nw_data),
		.re   (ctl.uw.rd_en),
		.raddr(rd_addr),
		.rdata(a_link)
	);

	iqmn_ram #(
		.WIDTH(SW),
		.DEPTH(NUM_SLOTS)
	) u_older (
		.clk  (clk),
		.we   (ol_we),
		.waddr(ol_addr),
		.wdata(ol_data),
		.re   (ctl.uw.rd_en),
		.raddr(rd_addr),
		.rdata(b_link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			head_q <= SENT_LINK;
			tail_q <= SENT_LINK;
			present_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			case (ctl.uw.hd)
				HD_X_IF_EMPTY: begin
					if (tail_sent) begin
						head_q <= x_link;
					end
				end
				HD_A_IF_B_SENT: begin
					if (b_sent) begin
						head_q <= a_link;
					end
				end
				HD_A: begin
					head_q <= a_link;
				end
				default: begin
					head_q <= head_q;
				end
			endcase
			case (ctl.uw.tl)
				TL_X: begin
					tail_q <= x_link;
				end
				TL_SENT_IF_A_SENT: begin
					if (a_sent) begin
						tail_q <= SENT_LINK;
					end
				end
				default: begin
					tail_q <= tail_q;
				end
			endcase
			case (ctl.uw.pr)
				PR_SET_X: begin
					present_q[x_addr] <= 1'b1;
				end
				PR_CLR_HEAD: begin
					present_q[head_addr] <= 1'b0;
				end
				default: begin
					present_q <= present_q;
				end
			endcase
			if (ctl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			idx_q <= index;
			act_q <= action;
			value_q <= '0;
		end else if (ctl.uw.val_ld) begin
			value_q <= INDEX_W'(head_addr);
		end
		if (ctl.out_ld) begin
			status_q <= ctl.uw.status;
			out_value_q <= value_q;
		end
	end

	always_comb begin
		flags.act_get = (act_q == ACT_GET);
		flags.range_err = ({1'b0, idx_q} >= capacity_q) || ({1'b0, idx_q} >= SLOTS_CAP);
		flags.present = present_q[x_addr];
		flags.is_tail = (tail_q == x_link);
		flags.empty = (head_q == SENT_LINK);
		flags.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign value = out_value_q;

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == SENT_LINK) == (tail_q == SENT_LINK))
		else $error("Oldest and newest pointers disagree on an empty queue.");

	a_head_present: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != SENT_LINK) |-> present_q[head_addr])
		else $error("Oldest entry is not marked present.");

	a_tail_present: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q != SENT_LINK) |-> present_q[tail_q[AW-1:0]])
		else $error("Newest entry is not marked present.");

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_RANGE || status_q == ST_EMPTY)) |->
		(out_value_q == '0))
		else $error("A failed request carries a nonzero value.");

	a_get_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.uw.pr == PR_CLR_HEAD) |=> !present_q[$past(head_addr)])
		else $error("A get left the removed index marked present.");

endmodule

/* src/indexed_queue_move_to_newest_core.sv */
// Queue of distinct indices in arrival order, with move-to-newest on a repeated put.
// Request channel: in_valid/in_stall carry action (0 put index, 1 get oldest) and index.
// A request is taken at a clock edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall carry status (0 ok, 1 out of range, 2 empty)
// and value, the index removed by a successful get, zero otherwise.
// Every request gives exactly one result, in request order.
// cfg_we with cfg_wdata writes the capacity; write it only while the block is idle.
// A microcoded sequencer steps through the link memories, one write per memory a step.
// After fetch and decode a request goes straight to a finish step (error or put of the
// newest index), or first through the get step (get), LINK_A and LINK_B (put of a new
// index) or the move step, LINK_A and LINK_B (move to newest), then to the finish step.
// A finished result waits in an output register; the next request is taken meanwhile,
// and the sequencer holds in its final step only while an earlier result is still stalled.
// Reset empties the queue, clears all presence bits and sets the capacity to 256;
// no clearing pass is needed.
module indexed_queue_move_to_newest_core #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [iqmn_pkg::CAP_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [iqmn_pkg::INDEX_W-1:0]    index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [iqmn_pkg::INDEX_W-1:0]    value
);

	import iqmn_pkg::*;

	ctl_t   ctl;
	flags_t flags;

	iqmn_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.flags   (flags),
		.ctl     (ctl)
	);

	iqmn_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.flags    (flags),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.action   (action),
		.index    (index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.value    (value)
	);

endmodule
